### sv/pixel_bin_average_unit_macros.svh
// Assertion macros shared by the pixel bin averaging unit.
`ifndef PIXEL_BIN_AVERAGE_UNIT_MACROS_SVH
`define PIXEL_BIN_AVERAGE_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define PBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/pba_pkg.sv
// Shared widths, defaults and register indexes of the pixel bin averaging unit.
package pba_pkg;

  localparam int DIM_BITS      = 10;
  localparam int BSZ_BITS      = 5;
  localparam int PIXEL_BITS    = 24;
  localparam int SUM_BITS      = 32;
  localparam int IDX_OUT_BITS  = 9;
  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;

  localparam int MAX_ROWS_DEF = 512;
  localparam int MAX_COLS_DEF = 512;
  localparam int MAX_BIN_DEF  = 16;

  localparam logic [DIM_BITS-1:0] ROWS_RST = 10'd512;
  localparam logic [DIM_BITS-1:0] COLS_RST = 10'd512;
  localparam logic [BSZ_BITS-1:0] BSZ_RST  = 5'd2;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_FRAME_ROWS = 2'd0;
  localparam reg_idx_t REG_FRAME_COLS = 2'd1;
  localparam reg_idx_t REG_BIN_SIZE   = 2'd2;

endpackage

### sv/pixel_bin_average_unit.sv
// Pixel bin averaging unit: box downsampling of a detector panel in raster order.
//
// Pixels enter on pixel_value with pixel_valid/pixel_ready, one word per
// pixel, row by row. Each bin_size x bin_size square (partial at the right
// and bottom edges) yields one word on bin_mean/bin_row/bin_col/frame_done
// with bin_valid/bin_ready; frame_done marks the last bin of the panel.
// Running sums for the current bin row live in one single-port-write,
// registered-read memory, one entry per bin column.
// A pixel that does not close a bin passes through read, then add and write
// back. A pixel that closes a bin passes through read, write back, 32 steps
// of the bit-serial divider, then the output load.
// The output register holds one result; a new pixel is taken while it waits.
// If the receiver stalls, the next bin-closing pixel holds in its final step
// until the output register frees, and pixel_ready stays low meanwhile.
// Reset restores frame_rows=512, frame_cols=512, bin_size=2 and restarts the
// panel; the sum memory needs no clearing, since the first pixel of each bin
// overwrites its entry. Any register write also restarts the panel.
`include "pixel_bin_average_unit_macros.svh"

module pixel_bin_average_unit import pba_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_BIN  = MAX_BIN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [APB_ADDR_BITS-1:0]        paddr,
  input  logic [APB_DATA_BITS-1:0]        pwdata,
  output logic [APB_DATA_BITS-1:0]        prdata,
  output logic                            pready,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  logic signed [PIXEL_BITS-1:0]    pixel_value,
  output logic                            bin_valid,
  input  logic                            bin_ready,
  output logic signed [PIXEL_BITS-1:0]    bin_mean,
  output logic [IDX_OUT_BITS-1:0]         bin_row,
  output logic [IDX_OUT_BITS-1:0]         bin_col,
  output logic                            frame_done
);

  localparam int DIM_MAX  = (1 << DIM_BITS) - 1;
  localparam int BSZ_MAX  = (1 << BSZ_BITS) - 1;
  localparam int ROWS_CAP = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
  localparam int COLS_CAP = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
  localparam int BIN_CAP  = (MAX_BIN > BSZ_MAX) ? BSZ_MAX : MAX_BIN;
  localparam int BIN_W    = (BIN_CAP > 1) ? $clog2(BIN_CAP) : 1;
  localparam int CNT_W    = $clog2(BIN_CAP * BIN_CAP + 1);
  localparam int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DCNT_W   = $clog2(SUM_BITS);

  localparam logic [SUM_BITS-1:0] MAG_HI = SUM_BITS'((1 << (PIXEL_BITS - 1)) - 1);
  localparam logic [SUM_BITS-1:0] MAG_LO = MAG_HI + 1'b1;
  localparam logic [PIXEL_BITS-1:0] MEAN_HI = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic [PIXEL_BITS-1:0] MEAN_LO = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ADD  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Configuration registers and their clamped values
  logic [DIM_BITS-1:0] frame_rows, frame_cols;
  logic [BSZ_BITS-1:0] bin_size;
  logic [DIM_BITS-1:0] rows_use, cols_use;
  logic [BSZ_BITS-1:0] bs_use;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // Panel position
  logic [DIM_BITS-1:0] pixel_row, pixel_col, bin_col_idx, bin_row_idx;
  logic [BIN_W-1:0]    row_in_bin, col_in_bin;
  logic                col_last, row_last, cib_last, rib_last;
  logic                last_c, last_r, panel_end, bin_first;
  logic [CNT_W-1:0]    rib1, cib1;

  // Item in flight
  logic [1:0]                   state;
  logic                         accept;
  logic signed [PIXEL_BITS-1:0] it_px;
  logic                         it_first, it_emit, it_end;
  logic [CNT_W-1:0]             it_cnt;
  logic [ADDR_W-1:0]            it_addr;
  logic [IDX_OUT_BITS-1:0]      it_row, it_col;

  // Sum memory
  logic [SUM_BITS-1:0] sums_mem [MAX_COLS];
  logic [SUM_BITS-1:0] rd_data, new_sum, px_ext;
  logic [ADDR_W-1:0]   rd_addr;
  logic                mem_we;

  // Divider
  logic [SUM_BITS-1:0] dvd, neg_q;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      rem_sh;
  logic                rem_ge, neg;
  logic [DCNT_W-1:0]   dcnt;
  logic                out_free;
  logic [PIXEL_BITS-1:0] mean_sat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  // Write the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_RST;
      frame_cols <= COLS_RST;
      bin_size   <= BSZ_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_ROWS: frame_rows <= pwdata[DIM_BITS-1:0];
        REG_FRAME_COLS: frame_cols <= pwdata[DIM_BITS-1:0];
        REG_BIN_SIZE:   bin_size   <= pwdata[BSZ_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read back the configuration registers
  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_ROWS: prdata = APB_DATA_BITS'(frame_rows);
      REG_FRAME_COLS: prdata = APB_DATA_BITS'(frame_cols);
      REG_BIN_SIZE:   prdata = APB_DATA_BITS'(bin_size);
      default:        prdata = '0;
    endcase
  end

  // Clamp the registers into their usable ranges
  always_comb begin
    if (frame_rows == '0)                        rows_use = DIM_BITS'(1);
    else if (frame_rows > DIM_BITS'(ROWS_CAP))   rows_use = DIM_BITS'(ROWS_CAP);
    else                                         rows_use = frame_rows;
    if (frame_cols == '0)                        cols_use = DIM_BITS'(1);
    else if (frame_cols > DIM_BITS'(COLS_CAP))   cols_use = DIM_BITS'(COLS_CAP);
    else                                         cols_use = frame_cols;
    if (bin_size == '0)                          bs_use = BSZ_BITS'(1);
    else if (bin_size > BSZ_BITS'(BIN_CAP))      bs_use = BSZ_BITS'(BIN_CAP);
    else                                         bs_use = bin_size;
  end

  // Decode the position of the incoming pixel
  assign col_last  = ((DIM_BITS+1)'(pixel_col) + 1'b1) >= (DIM_BITS+1)'(cols_use);
  assign row_last  = ((DIM_BITS+1)'(pixel_row) + 1'b1) >= (DIM_BITS+1)'(rows_use);
  assign cib_last  = ((BSZ_BITS+1)'(col_in_bin) + 1'b1) >= (BSZ_BITS+1)'(bs_use);
  assign rib_last  = ((BSZ_BITS+1)'(row_in_bin) + 1'b1) >= (BSZ_BITS+1)'(bs_use);
  assign last_c    = cib_last | col_last;
  assign last_r    = rib_last | row_last;
  assign panel_end = row_last & col_last;
  assign bin_first = (row_in_bin == '0) && (col_in_bin == '0);
  assign rib1      = CNT_W'(row_in_bin) + 1'b1;
  assign cib1      = CNT_W'(col_in_bin) + 1'b1;
  assign rd_addr   = ADDR_W'(bin_col_idx);

  assign pixel_ready = (state == ST_IDLE);
  assign accept      = pixel_valid & pixel_ready;

  // Advance the panel position; restart on any register write
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pixel_row   <= '0;
      pixel_col   <= '0;
      row_in_bin  <= '0;
      col_in_bin  <= '0;
      bin_col_idx <= '0;
      bin_row_idx <= '0;
    end else if (accept) begin
      if (col_last) begin
        pixel_col   <= '0;
        col_in_bin  <= '0;
        bin_col_idx <= '0;
        if (row_last) begin
          pixel_row   <= '0;
          row_in_bin  <= '0;
          bin_row_idx <= '0;
        end else begin
          pixel_row <= pixel_row + 1'b1;
          if (rib_last) begin
            row_in_bin  <= '0;
            bin_row_idx <= bin_row_idx + 1'b1;
          end else begin
            row_in_bin <= row_in_bin + 1'b1;
          end
        end
      end else begin
        pixel_col <= pixel_col + 1'b1;
        if (cib_last) begin
          col_in_bin  <= '0;
          bin_col_idx <= bin_col_idx + 1'b1;
        end else begin
          col_in_bin <= col_in_bin + 1'b1;
        end
      end
    end
  end

  // Capture the accepted pixel and what it means for its bin
  always_ff @(posedge clk) begin
    if (accept) begin
      it_px    <= pixel_value;
      it_first <= bin_first;
      it_emit  <= last_c & last_r;
      it_end   <= panel_end;
      it_cnt   <= CNT_W'(rib1 * cib1);
      it_addr  <= rd_addr;
      it_row   <= bin_row_idx[IDX_OUT_BITS-1:0];
      it_col   <= bin_col_idx[IDX_OUT_BITS-1:0];
    end
  end

  // Read the bin sum on accept, write it back in the following cycle
  assign px_ext  = {{(SUM_BITS-PIXEL_BITS){it_px[PIXEL_BITS-1]}}, it_px};
  assign new_sum = it_first ? px_ext : rd_data + px_ext;
  assign mem_we  = (state == ST_ADD);

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= sums_mem[rd_addr];
    end
    if (mem_we) begin
      sums_mem[it_addr] <= new_sum;
    end
  end

  // One restoring step of the divider on the magnitude of the sum
  assign rem_sh = {rem, dvd[SUM_BITS-1]};
  assign rem_ge = rem_sh >= (CNT_W+1)'(it_cnt);

  // Sign and saturate the quotient
  assign neg_q = '0 - dvd;
  always_comb begin
    if (neg) begin
      mean_sat = (dvd > MAG_LO) ? MEAN_LO : neg_q[PIXEL_BITS-1:0];
    end else begin
      mean_sat = (dvd > MAG_HI) ? MEAN_HI : dvd[PIXEL_BITS-1:0];
    end
  end

  assign out_free = ~bin_valid | bin_ready;

  // Sequence read, write back, divide and output load
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (accept) state <= ST_ADD;
        ST_ADD:  state <= it_emit ? ST_DIV : ST_IDLE;
        ST_DIV:  if (dcnt == DCNT_W'(SUM_BITS - 1)) state <= ST_DONE;
        ST_DONE: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Load and step the divider
  always_ff @(posedge clk) begin
    if (state == ST_ADD) begin
      neg  <= new_sum[SUM_BITS-1];
      dvd  <= new_sum[SUM_BITS-1] ? ('0 - new_sum) : new_sum;
      rem  <= '0;
      dcnt <= '0;
    end else if (state == ST_DIV) begin
      rem  <= rem_ge ? CNT_W'(rem_sh - (CNT_W+1)'(it_cnt)) : CNT_W'(rem_sh);
      dvd  <= {dvd[SUM_BITS-2:0], rem_ge};
      dcnt <= dcnt + 1'b1;
    end
  end

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      bin_valid <= 1'b1;
    end else if (bin_ready) begin
      bin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      bin_mean   <= mean_sat;
      bin_row    <= it_row;
      bin_col    <= it_col;
      frame_done <= it_end;
    end
  end

  // Checks on the sequencer and the position counters
  `PBA_ASSERT_NEXT(a_accept_to_add, accept, state == ST_ADD, "accepted pixel skipped write back")
  `PBA_ASSERT_SAME(a_div_nonzero, state == ST_DIV, it_cnt != '0, "divider started with zero count")
  `PBA_ASSERT_NEXT(a_done_holds, (state == ST_DONE) && bin_valid && !bin_ready, state == ST_DONE, "result dropped while output stalled")
  `PBA_ASSERT_SAME(a_bin_pos, state == ST_IDLE, (BSZ_BITS'(row_in_bin) < bs_use) && (BSZ_BITS'(col_in_bin) < bs_use), "position inside bin out of range")

endmodule

### tb/tb_pixel_bin_average_unit.sv
// Self-checking testbench of the pixel bin averaging unit, with its own bin predictor.
module tb_pixel_bin_average_unit import pba_pkg::*; ();

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef struct {
    logic signed [PIXEL_BITS-1:0] mean;
    logic [IDX_OUT_BITS-1:0]      row;
    logic [IDX_OUT_BITS-1:0]      col;
    logic                         done;
  } bin_word_t;

  typedef enum int {FILL_MIX, FILL_MAX, FILL_MIN} fill_mode_t;

  // Unused register slot: a write there only restarts the panel.
  localparam reg_idx_t REG_SPARE = 2'd3;

  localparam pixel_t PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam pixel_t PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};
  localparam longint MEAN_HI = (longint'(1) << (PIXEL_BITS-1)) - 1;
  localparam longint MEAN_LO = -MEAN_HI - 1;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DRAIN_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 300;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     pixel_valid = 1'b0;
  logic                     pixel_ready;
  pixel_t                   pixel_value = '0;
  logic                     bin_valid;
  logic                     bin_ready = 1'b0;
  logic signed [PIXEL_BITS-1:0] bin_mean;
  logic [IDX_OUT_BITS-1:0]  bin_row;
  logic [IDX_OUT_BITS-1:0]  bin_col;
  logic                     frame_done;

  pixel_bin_average_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel_value(pixel_value),
    .bin_valid(bin_valid), .bin_ready(bin_ready), .bin_mean(bin_mean),
    .bin_row(bin_row), .bin_col(bin_col), .frame_done(frame_done)
  );

  // Stimulus and expectation stores
  pixel_t    pending_pixels[$];
  bin_word_t expected_bins[$];
  int        sent_count = 0;
  int        taken_count = 0;
  int        mismatches = 0;
  int        missing_words = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_request = 1'b0;
  bit        hold_served = 1'b0;

  // Predictor copy of the configuration and the binning state
  logic [DIM_BITS-1:0]  cfg_rows = ROWS_RST;
  logic [DIM_BITS-1:0]  cfg_cols = COLS_RST;
  logic [BSZ_BITS-1:0]  cfg_bin  = BSZ_RST;
  logic [SUM_BITS-1:0]  col_sums [MAX_COLS_DEF];
  int unsigned pos_row = 0;
  int unsigned pos_col = 0;
  int unsigned sub_row = 0;
  int unsigned sub_col = 0;
  int unsigned bin_idx = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_panel();
    pos_row = 0;
    pos_col = 0;
    sub_row = 0;
    sub_col = 0;
    bin_idx = 0;
  endfunction

  function automatic void apply_config(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
    case (idx)
      REG_FRAME_ROWS: cfg_rows = value[DIM_BITS-1:0];
      REG_FRAME_COLS: cfg_cols = value[DIM_BITS-1:0];
      REG_BIN_SIZE:   cfg_bin  = value[BSZ_BITS-1:0];
      default: ;
    endcase
    restart_panel();
  endfunction

  // Accumulate one pixel; return 1 with the bin word when it closes a bin.
  function automatic bit predict_bin(pixel_t px, output bin_word_t w);
    int unsigned rows, cols, bs;
    bit last_c, last_r, panel_end, closes;
    longint sum, cnt, q;
    rows = clamp_cfg(32'(cfg_rows), MAX_ROWS_DEF);
    cols = clamp_cfg(32'(cfg_cols), MAX_COLS_DEF);
    bs   = clamp_cfg(32'(cfg_bin), MAX_BIN_DEF);
    last_c = (sub_col + 1 >= bs) || (pos_col + 1 >= cols);
    last_r = (sub_row + 1 >= bs) || (pos_row + 1 >= rows);
    panel_end = (pos_row + 1 >= rows) && (pos_col + 1 >= cols);
    closes = last_c && last_r;
    w = '{mean: '0, row: '0, col: '0, done: 1'b0};

    // First pixel of a bin overwrites its column sum
    if (sub_row == 0 && sub_col == 0)
      col_sums[bin_idx] = {{(SUM_BITS-PIXEL_BITS){px[PIXEL_BITS-1]}}, px};
    else
      col_sums[bin_idx] = col_sums[bin_idx] + {{(SUM_BITS-PIXEL_BITS){px[PIXEL_BITS-1]}}, px};

    if (closes) begin
      sum = longint'($signed(col_sums[bin_idx]));
      cnt = longint'((sub_row + 1) * (sub_col + 1));
      q = sum / cnt;
      if (q > MEAN_HI) q = MEAN_HI;
      if (q < MEAN_LO) q = MEAN_LO;
      w.mean = q[PIXEL_BITS-1:0];
      w.row  = IDX_OUT_BITS'(pos_row / bs);
      w.col  = IDX_OUT_BITS'(bin_idx);
      w.done = panel_end;
    end

    // Advance the raster position
    if (pos_col + 1 >= cols) begin
      pos_col = 0;
      sub_col = 0;
      bin_idx = 0;
      if (pos_row + 1 >= rows) begin
        pos_row = 0;
        sub_row = 0;
      end else begin
        pos_row++;
        sub_row = (sub_row + 1 >= bs) ? 0 : sub_row + 1;
      end
    end else begin
      pos_col++;
      if (sub_col + 1 >= bs) begin
        sub_col = 0;
        bin_idx++;
      end else begin
        sub_col++;
      end
    end
    return closes;
  endfunction

  function automatic pixel_t gen_pixel(fill_mode_t mode);
    int unsigned pick;
    int small_val;
    case (mode)
      FILL_MAX: return PIX_MAX;
      FILL_MIN: return PIX_MIN;
      default: begin
        pick = $urandom_range(0, 7);
        small_val = int'($urandom_range(0, 16)) - 8;
        case (pick)
          0: return PIX_MAX;
          1: return PIX_MIN;
          2: return pixel_t'(small_val);
          default: return pixel_t'($urandom());
        endcase
      end
    endcase
  endfunction

  // Write one register through a setup and an access phase
  task automatic reg_write(reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    apply_config(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    @(posedge clk);
  endtask

  // Wait for every pixel to be taken, then for the bin words up to the drain limit
  task automatic drain_block();
    int waited;
    waited = 0;
    while (pending_pixels.size() > 0 || sent_count != taken_count) @(posedge clk);
    while (expected_bins.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bins.size() > 0) begin
      $display("%0t: %0d expected bin words never arrived", $time, expected_bins.size());
      missing_words += expected_bins.size();
      expected_bins.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned rows, int unsigned cols, int unsigned bs,
                           int unsigned count, fill_mode_t mode);
    reg_write(REG_FRAME_ROWS, rows);
    reg_write(REG_FRAME_COLS, cols);
    reg_write(REG_BIN_SIZE, bs);
    for (int i = 0; i < count; i++) pending_pixels.push_back(gen_pixel(mode));
    drain_block();
  endtask

  // Pixel driver: hold the word until taken, then move on or idle
  always @(negedge clk) begin : pixel_driver
    int gap_left;
    if (!rst && !(pixel_valid && sent_count != taken_count)) begin
      if (!no_idle && gap_left == 0 && $urandom_range(0, 5) == 0)
        gap_left = $urandom_range(1, 17);
      if (gap_left > 0) begin
        gap_left--;
        pixel_valid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        pixel_value <= pending_pixels.pop_front();
        pixel_valid <= 1'b1;
        sent_count++;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls and one long hold-off on request
  always @(negedge clk) begin : bin_receiver
    int stall_left;
    int hold_count;
    if (hold_request && !hold_served) begin
      bin_ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) hold_served = 1'b1;
    end else begin
      if (!no_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
        stall_left--;
        bin_ready <= 1'b0;
      end else begin
        bin_ready <= 1'b1;
      end
    end
  end

  // Monitor: check bin words, then predict from taken pixels
  always @(posedge clk) begin : monitor
    bin_word_t want;
    bin_word_t got;
    if (!rst && bin_valid && bin_ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin word mean %0d row %0d col %0d done %0b",
                 $time, bin_mean, bin_row, bin_col, frame_done);
        mismatches++;
      end else begin
        want = expected_bins.pop_front();
        if (bin_mean !== want.mean) begin
          $display("%0t: bin_mean expected %0d, got %0d", $time, want.mean, bin_mean);
          mismatches++;
        end
        if (bin_row !== want.row) begin
          $display("%0t: bin_row expected %0d, got %0d", $time, want.row, bin_row);
          mismatches++;
        end
        if (bin_col !== want.col) begin
          $display("%0t: bin_col expected %0d, got %0d", $time, want.col, bin_col);
          mismatches++;
        end
        if (frame_done !== want.done) begin
          $display("%0t: frame_done expected %0b, got %0b", $time, want.done, frame_done);
          mismatches++;
        end
      end
    end
    if (!rst && pixel_valid && pixel_ready) begin
      taken_count++;
      if (predict_bin(pixel_value, got)) expected_bins.push_back(got);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main sequence
  initial begin : sequencer
    int dvals_a [7];
    int dvals_b [15];
    int unsigned rows, cols, bs, panel, count, small_total, phases;
    dvals_a = '{8388607, 8388607, -8388608, 1, -1, 8388607, 8388607};
    dvals_b = '{-8388608, -8388608, -7, 0, -7,
                -8388608, -8388608, 2, 0, 2,
                -5, 1, 3, -3, -1};
    small_total = 0;
    phases = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Pixels under the reset configuration: first row only, no bins close
    pending_pixels.push_back(PIX_MAX);
    pending_pixels.push_back(PIX_MIN);
    pending_pixels.push_back('0);
    drain_block();

    // Small panel with partial edge bins; restart mid-panel by a spare write
    reg_write(REG_FRAME_ROWS, 3);
    reg_write(REG_FRAME_COLS, 5);
    reg_write(REG_BIN_SIZE, 2);
    foreach (dvals_a[i]) pending_pixels.push_back(pixel_t'(dvals_a[i]));
    drain_block();
    reg_write(REG_SPARE, 32'h0000_0007);
    foreach (dvals_b[i]) pending_pixels.push_back(pixel_t'(dvals_b[i]));
    drain_block();

    // Long receiver hold-off while one bin closes per pixel
    hold_request = 1'b1;
    run_phase(4, 8, 1, 64, FILL_MIX);

    // Random small panels and bin sizes
    while (small_total < 150 || phases < 6) begin
      rows = $urandom_range(1, 10);
      cols = $urandom_range(1, 10);
      bs = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      panel = rows * cols;
      count = panel + $urandom_range(0, panel);
      if (count > 80) count = 80;
      run_phase(rows, cols, bs, count, FILL_MIX);
      small_total += count;
      phases++;
    end

    // Saturated settings: widest row with bin 1, tallest column with bin 16
    run_phase(0, 1023, 0, 64, FILL_MIX);
    run_phase(1023, 0, 31, 64, FILL_MIX);

    // Full 16 by 16 bins at the pixel extremes, then a one-pixel panel, without idling
    no_idle = 1'b1;
    run_phase(16, 16, 16, 256, FILL_MAX);
    run_phase(16, 16, 16, 256, FILL_MIN);
    run_phase(1, 1, 16, 20, FILL_MIX);

    if (mismatches == 0 && missing_words == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
